// File: hw/rtl/multi_mode_timer_slots_core_macros.svh
// Assertion macros used by the checker file.
`ifndef MULTI_MODE_TIMER_SLOTS_CORE_MACROS_SVH
`define MULTI_MODE_TIMER_SLOTS_CORE_MACROS_SVH

// Clocked assertion with reset disable.
`define MMTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication from one condition to the next cycle.
`define MMTS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: hw/rtl/mmts_pkg.sv
package mmts_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = 4;
  localparam int CNT_W  = 5;
  localparam int START_W = 49;
  localparam int DUR_W   = 41;
  localparam int NOW_W   = 48;
  localparam int ELA_W   = 40;
  localparam int BAND_W  = 20;
  localparam int CALC_W  = 52;

  localparam logic [1:0] KIND_FIRE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;

  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_INSTALL = 1'b1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_ACK  = 2'd3;

  typedef struct packed {
    logic                      valid;
    logic                      list;
    logic signed [START_W-1:0] start;
    logic signed [DUR_W-1:0]   dur;
  } slot_t;

  typedef struct packed {
    logic [NOW_W-1:0]  now;
    logic [ELA_W-1:0]  elapsed;
    logic [BAND_W-1:0] band;
    logic              list;
    logic              first;
  } walk_ctl_t;

endpackage

// File: hw/rtl/multi_mode_timer_slots_core.sv
// Timer slot table built as a ring of sixteen slot cells.
// Input channel: in_valid/in_stall; one transaction is either an install
// (action 1) or a tick over one list (action 0).
// An install writes one slot and returns one acknowledge transaction holding
// the live count of that list once the output register can take it.
// A tick rotates the ring once: the slot at the head is checked each cycle
// while the output is free, so the walk visits all sixteen slots before the
// finishing transaction. Each firing slot gives one result transaction during
// the walk. During a tick, in_stall stays high until the last result of the
// transaction is in the output register. Output channel: out_valid/out_stall
// with a registered output; while the receiver stalls, the walk pauses and
// the result holds. The user must write the zero band register through
// cfg_we/cfg_data only while idle; the block does not enforce this. Reset
// clears all slot valid bits and the output valid, and sets the band to 1000.
module multi_mode_timer_slots_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic        in_list_select,
  input  logic [3:0]  in_slot,
  input  logic [47:0] in_now_us,
  input  logic [39:0] in_elapsed_us,
  input  logic signed [48:0] in_start_us,
  input  logic signed [40:0] in_duration_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_fired_slot,
  output logic [39:0] out_elapsed_out,
  output logic [4:0]  out_live_count,
  output logic        out_last
);
  import mmts_pkg::*;

  logic [1:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, pop;
  logic [BAND_W-1:0] band_r;
  walk_ctl_t         ctl_r, ctl_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [SLOT_W-1:0] fs_r, fs_nxt;
  logic [ELA_W-1:0]  el_r, el_nxt;
  logic [CNT_W-1:0]  lc_r, lc_nxt;
  logic              last_r, last_nxt;

  slot_t cell_q [SLOTS];
  slot_t cell_d [SLOTS];
  slot_t ld, head_new;
  logic  shift, accept, can_put, fire, member;

  assign accept  = in_valid && !in_stall;
  assign can_put = !out_valid_r || !out_stall;
  assign shift   = (state_r == ST_WALK) && can_put;
  assign in_stall = (state_r != ST_IDLE);

  assign ld.valid = 1'b1;
  assign ld.list  = in_list_select;
  assign ld.start = in_start_us;
  assign ld.dur   = in_duration_us;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      assign cell_d[i] = head_new;
    end else begin : g_mid
      assign cell_d[i] = cell_q[i+1];
    end
    mmts_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (shift),
      .d_in  (cell_d[i]),
      .load  (accept && (in_action == ACT_INSTALL) && (in_slot == SLOT_W'(i))),
      .ld    (ld),
      .q     (cell_q[i])
    );
  end

  mmts_eval u_eval (
    .s_in   (cell_q[0]),
    .ctl    (ctl_r),
    .s_out  (head_new),
    .fire   (fire),
    .member (member)
  );

  always_comb begin
    pop = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (cell_q[i].valid && (cell_q[i].list == ctl_r.list)) begin
        pop = pop + CNT_W'(1);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    ctl_nxt       = ctl_r;
    out_valid_nxt = can_put ? 1'b0 : out_valid_r;
    kind_nxt      = kind_r;
    fs_nxt        = fs_r;
    el_nxt        = el_r;
    lc_nxt        = lc_r;
    last_nxt      = last_r;
    ctl_nxt.band  = band_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ctl_nxt.now     = in_now_us;
          ctl_nxt.elapsed = in_elapsed_us;
          ctl_nxt.list    = in_list_select;
          ctl_nxt.first   = 1'b1;
          idx_nxt         = in_slot;
          cnt_nxt         = '0;
          state_nxt       = (in_action == ACT_INSTALL) ? ST_ACK : ST_WALK;
          if (in_action == ACT_TICK) begin
            idx_nxt = '0;
          end
        end
      end
      ST_WALK: begin
        if (can_put) begin
          if (member) begin
            ctl_nxt.first = 1'b0;
          end
          if (head_new.valid && head_new.list == ctl_r.list) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (fire) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = KIND_FIRE;
            fs_nxt        = idx_r;
            el_nxt        = ctl_r.elapsed;
            lc_nxt        = '0;
            last_nxt      = 1'b0;
          end
          idx_nxt = idx_r + SLOT_W'(1);
          if (idx_r == SLOT_W'(SLOTS - 1)) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (can_put) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_DONE;
          fs_nxt        = '0;
          el_nxt        = '0;
          lc_nxt        = cnt_r;
          last_nxt      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_ACK: begin
        if (can_put) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_ACK;
          fs_nxt        = idx_r;
          el_nxt        = '0;
          lc_nxt        = pop;
          last_nxt      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      band_r      <= BAND_W'(1000);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        band_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    ctl_r  <= ctl_nxt;
    kind_r <= kind_nxt;
    fs_r   <= fs_nxt;
    el_r   <= el_nxt;
    lc_r   <= lc_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_fired_slot  = fs_r;
  assign out_elapsed_out = el_r;
  assign out_live_count  = lc_r;
  assign out_last        = last_r;

endmodule

// File: hw/rtl/mmts_cell.sv
module mmts_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift,
  input  mmts_pkg::slot_t d_in,
  input  logic           load,
  input  mmts_pkg::slot_t ld,
  output mmts_pkg::slot_t q
);
  import mmts_pkg::*;

  logic                      valid_r;
  logic                      list_r;
  logic signed [START_W-1:0] start_r;
  logic signed [DUR_W-1:0]   dur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      list_r  <= 1'b0;
    end else if (shift) begin
      valid_r <= d_in.valid;
      list_r  <= d_in.list;
    end else if (load) begin
      valid_r <= ld.valid;
      list_r  <= ld.list;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      start_r <= d_in.start;
      dur_r   <= d_in.dur;
    end else if (load) begin
      start_r <= ld.start;
      dur_r   <= ld.dur;
    end
  end

  assign q.valid = valid_r;
  assign q.list  = list_r;
  assign q.start = start_r;
  assign q.dur   = dur_r;

endmodule

// File: hw/rtl/mmts_eval.sv
module mmts_eval (
  input  mmts_pkg::slot_t     s_in,
  input  mmts_pkg::walk_ctl_t ctl,
  output mmts_pkg::slot_t     s_out,
  output logic                fire,
  output logic                member
);
  import mmts_pkg::*;

  logic signed [CALC_W-1:0] s, d, n, lo, b, sum, dif, smax;
  logic check;

  always_comb begin
    s    = CALC_W'(s_in.start);
    d    = CALC_W'(s_in.dur);
    n    = $signed({{(CALC_W-NOW_W){1'b0}}, ctl.now});
    lo   = n - $signed({{(CALC_W-ELA_W){1'b0}}, ctl.elapsed});
    b    = $signed({{(CALC_W-BAND_W){1'b0}}, ctl.band});
    sum  = s + d;
    dif  = s - d;
    smax = $signed({{(CALC_W-NOW_W){1'b0}}, {NOW_W{1'b1}}});
    member = s_in.valid && (s_in.list == ctl.list);
    check  = member && ((s > 0) || ctl.first);
    s_out  = s_in;
    fire   = 1'b0;
    if (check) begin
      if (d > b) begin
        if (s < n && sum > n) begin
          fire = 1'b1;
        end else if (sum < n) begin
          s_out.valid = 1'b0;
        end
      end else if (d < -b) begin
        if (s < n && dif > n) begin
          fire = 1'b1;
        end
        if (dif < n || (s < n && dif > n)) begin
          s_out.start = (dif > smax) ? START_W'(smax) : START_W'(dif);
        end
      end else begin
        if (s > lo && s <= n) begin
          fire = 1'b1;
          s_out.valid = 1'b0;
        end
      end
    end
  end

endmodule

// File: hw/rtl/mmts_checker.sv
`include "multi_mode_timer_slots_core_macros.svh"

module mmts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [4:0] out_live_count,
  input logic       out_last
);
  import mmts_pkg::*;

  `MMTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_kind), "stalled result changed")
  `MMTS_ASSERT(a_kind_ok, clk, rst_n, !out_valid || out_kind == KIND_FIRE || out_kind == KIND_DONE || out_kind == KIND_ACK, "illegal result kind")
  `MMTS_ASSERT(a_fire_fields, clk, rst_n, !(out_valid && out_kind == KIND_FIRE) || (!out_last && out_live_count == '0), "fire result has count or last")
  `MMTS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "block not busy after a transaction")

endmodule

bind multi_mode_timer_slots_core mmts_checker u_mmts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_live_count (out_live_count),
  .out_last       (out_last)
);
